### rtl/vectored_interrupt_daisy_chain_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the vectored interrupt daisy chain
// Concurrent assertion shorthands clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef VECTORED_INTERRUPT_DAISY_CHAIN_MACROS_SVH
`define VECTORED_INTERRUPT_DAISY_CHAIN_MACROS_SVH

// Same-cycle implication.
`define VIDC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vidc assertion failed");

// Next-cycle implication.
`define VIDC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vidc assertion failed");

`endif

### rtl/vidc_pkg.sv
// ----------------------------------------------------------------------------
// vidc_pkg
// Types and constants shared by the vectored interrupt daisy chain modules.
// ----------------------------------------------------------------------------
package vidc_pkg;

	// Request type codes.
	localparam logic [2:0] REQ_RAISE  = 3'd0;
	localparam logic [2:0] REQ_CLEAR  = 3'd1;
	localparam logic [2:0] REQ_RESET  = 3'd2;
	localparam logic [2:0] REQ_ACK    = 3'd3;
	localparam logic [2:0] REQ_RETURN = 3'd4;
	localparam logic [2:0] REQ_CHAIN  = 3'd5;

	// Interrupt source codes, also the low bits of the vector code.
	localparam logic [1:0] SRC_TX     = 2'd0;
	localparam logic [1:0] SRC_STATUS = 2'd1;
	localparam logic [1:0] SRC_RX     = 2'd2;
	localparam logic [1:0] SRC_ERR    = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] CFG_CHAN_A = 2'd0;
	localparam logic [1:0] CFG_CHAN_B = 2'd1;
	localparam logic [1:0] CFG_BASE   = 2'd2;

	// Enable register layout.
	localparam int ENABLE_W = 5;
	localparam int ENB_STATUS = 0;
	localparam int ENB_TX = 1;
	localparam int ENB_SAV = 2;
	localparam logic [ENABLE_W-1:0] RX_MODE_MASK = 5'h18;

	// Vector constants.
	localparam logic [7:0] VEC_KEEP_MASK = 8'hf1;
	localparam logic [7:0] ACK_NONE = 8'hff;
	localparam logic [2:0] CODE_NONE = 3'd3;

	typedef struct packed {
		logic [2:0] req_type;
		logic       channel;
		logic [1:0] source;
		logic       chain_in_value;
	} req_t;

	typedef struct packed {
		logic       int_line;
		logic       chain_out;
		logic       request_pending;
		logic [7:0] vector_out;
		logic [7:0] ack_data;
	} rsp_t;

	// Per-channel pending flags as seen by the priority logic.
	typedef struct packed {
		logic err;
		logic rx;
		logic st;
		logic tx;
		logic isv;
	} chan_flags_t;

	// Result of the daisy-chain priority scan.
	typedef struct packed {
		logic       hit;
		logic       hit_ch;
		logic [1:0] hit_src;
		logic       any_req;
		logic [7:0] vector;
	} scan_t;

endpackage

### rtl/vidc_prio.sv
// ----------------------------------------------------------------------------
// vidc_prio
// Priority scan over both channels and vector formation.
// ----------------------------------------------------------------------------
module vidc_prio
	import vidc_pkg::*;
(
	input  chan_flags_t [1:0]          flags,
	input  logic [ENABLE_W-1:0]        en_a,
	input  logic [ENABLE_W-1:0]        en_b,
	input  logic [7:0]                 base_vector,
	output scan_t                      scan
);

	logic [ENABLE_W-1:0] en [2];
	logic [1:0] req;
	logic [1:0] src [2];
	logic hit0;
	logic hit1;
	logic [2:0] code;

	assign en[0] = en_a;
	assign en[1] = en_b;

	// Highest pending source of each channel: error, receive, status, transmit.
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			req[i] = 1'b1;
			if (flags[i].err) begin
				src[i] = SRC_ERR;
			end else if (flags[i].rx && ((en[i] & RX_MODE_MASK) != '0)) begin
				src[i] = SRC_RX;
			end else if (flags[i].st && en[i][ENB_STATUS]) begin
				src[i] = SRC_STATUS;
			end else if (flags[i].tx && en[i][ENB_TX]) begin
				src[i] = SRC_TX;
			end else begin
				src[i] = SRC_TX;
				req[i] = 1'b0;
			end
		end
	end

	// Channel A first; a channel in service stops the scan.
	assign hit0 = !flags[0].isv && req[0];
	assign hit1 = !flags[0].isv && !req[0] && !flags[1].isv && req[1];

	assign code = hit0 ? {1'b1, src[0]} : (hit1 ? {1'b0, src[1]} : CODE_NONE);

	assign scan.hit = hit0 || hit1;
	assign scan.hit_ch = !hit0;
	assign scan.hit_src = hit0 ? src[0] : src[1];
	assign scan.any_req = req[0] || req[1];
	assign scan.vector = en_b[ENB_SAV] ? ((base_vector & VEC_KEEP_MASK) | {4'b0, code, 1'b0})
		: base_vector;

endmodule

### rtl/vectored_interrupt_daisy_chain.sv
// ----------------------------------------------------------------------------
// vectored_interrupt_daisy_chain
// Two-channel vectored interrupt unit with daisy-chain priority.
// ----------------------------------------------------------------------------
// Usage:
//   Events enter on the req channel (req_valid/req_stall) and each event
//   produces exactly one response on the rsp channel (rsp_valid/rsp_stall)
//   with the interrupt line, chain enable out, request flag, current vector
//   and acknowledge data as they stand after the event.
//   The response is registered: a transaction accepted at one edge is shown
//   as a response after that edge. Throughput is one event per cycle while
//   no response is stalled, set by the single pass of next-state and priority
//   logic into the response register. req_stall rises only while a response
//   waits and rsp_stall is high; when the receiver takes the response, a new
//   event is accepted in the same cycle. A stalled response holds steady.
//   Configuration writes (cfg_valid/cfg_ready, always ready) set the channel
//   enables and base vector; index three is ignored. Write only while idle.
//   Reset clears all pending flags, counts, in-service flags and configuration
//   registers and sets chain enable in; no response is pending after reset.
// ----------------------------------------------------------------------------
module vectored_interrupt_daisy_chain
	import vidc_pkg::*;
#(
	parameter int RECV_COUNT_MAX = 15
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  req_t       req,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output rsp_t       rsp,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	localparam int CNT_W = $clog2(RECV_COUNT_MAX + 1);
	typedef logic [CNT_W-1:0] cnt_t;
	localparam cnt_t CNT_MAX = cnt_t'(RECV_COUNT_MAX);

	logic [ENABLE_W-1:0] en_a_q;
	logic [ENABLE_W-1:0] en_b_q;
	logic [7:0]          base_q;

	logic err_q [2];
	logic st_q  [2];
	logic tx_q  [2];
	logic isv_q [2];
	cnt_t cnt_q [2];
	logic chain_q;

	logic err_d [2];
	logic st_d  [2];
	logic tx_d  [2];
	logic isv_d [2];
	cnt_t cnt_d [2];
	logic chain_d;
	logic [7:0] ack_d;

	chan_flags_t [1:0] cur_flags;
	chan_flags_t [1:0] nxt_flags;
	scan_t cur_scan;
	scan_t nxt_scan;

	logic accept;
	logic rsp_valid_q;
	rsp_t rsp_q;

	assign cfg_ready = 1'b1;
	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	// Flags before and after the event, for the two priority scans.
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			cur_flags[i] = '{err: err_q[i], rx: (cnt_q[i] != '0), st: st_q[i],
				tx: tx_q[i], isv: isv_q[i]};
			nxt_flags[i] = '{err: err_d[i], rx: (cnt_d[i] != '0), st: st_d[i],
				tx: tx_d[i], isv: isv_d[i]};
		end
	end

	// Scan of the present state serves the acknowledge.
	vidc_prio u_prio_cur (
		.flags       (cur_flags),
		.en_a        (en_a_q),
		.en_b        (en_b_q),
		.base_vector (base_q),
		.scan        (cur_scan)
	);

	// Scan of the updated state serves the response.
	vidc_prio u_prio_nxt (
		.flags       (nxt_flags),
		.en_a        (en_a_q),
		.en_b        (en_b_q),
		.base_vector (base_q),
		.scan        (nxt_scan)
	);

	// Next state for the event on the request channel.
	always_comb begin
		err_d = err_q;
		st_d = st_q;
		tx_d = tx_q;
		isv_d = isv_q;
		cnt_d = cnt_q;
		chain_d = chain_q;
		ack_d = ACK_NONE;
		case (req.req_type)
			REQ_RAISE: begin
				case (req.source)
					SRC_TX:     tx_d[req.channel] = 1'b1;
					SRC_STATUS: st_d[req.channel] = 1'b1;
					SRC_RX: begin
						if (cnt_q[req.channel] < CNT_MAX) begin
							cnt_d[req.channel] = cnt_q[req.channel] + cnt_t'(1);
						end
					end
					default:    err_d[req.channel] = 1'b1;
				endcase
			end
			REQ_CLEAR: begin
				case (req.source)
					SRC_TX:     tx_d[req.channel] = 1'b0;
					SRC_STATUS: st_d[req.channel] = 1'b0;
					SRC_RX: begin
						if (cnt_q[req.channel] != '0) begin
							cnt_d[req.channel] = cnt_q[req.channel] - cnt_t'(1);
						end
					end
					default:    err_d[req.channel] = 1'b0;
				endcase
			end
			REQ_RESET: begin
				err_d[req.channel] = 1'b0;
				st_d[req.channel] = 1'b0;
				tx_d[req.channel] = 1'b0;
				cnt_d[req.channel] = '0;
			end
			REQ_ACK: begin
				if (cur_scan.hit) begin
					ack_d = cur_scan.vector;
					// The receive count stays; other sources are taken.
					case (cur_scan.hit_src)
						SRC_ERR:    err_d[cur_scan.hit_ch] = 1'b0;
						SRC_STATUS: st_d[cur_scan.hit_ch] = 1'b0;
						SRC_TX:     tx_d[cur_scan.hit_ch] = 1'b0;
						default: ;
					endcase
					isv_d[cur_scan.hit_ch] = 1'b1;
				end
			end
			REQ_RETURN: begin
				if (isv_q[0]) begin
					isv_d[0] = 1'b0;
				end else if (isv_q[1]) begin
					isv_d[1] = 1'b0;
				end
			end
			REQ_CHAIN: chain_d = req.chain_in_value;
			default: ;
		endcase
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_a_q <= '0;
			en_b_q <= '0;
			base_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_CHAN_A: en_a_q <= cfg_data[ENABLE_W-1:0];
				CFG_CHAN_B: en_b_q <= cfg_data[ENABLE_W-1:0];
				CFG_BASE:   base_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Interrupt state, updated on each accepted transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2; i++) begin
				err_q[i] <= 1'b0;
				st_q[i] <= 1'b0;
				tx_q[i] <= 1'b0;
				isv_q[i] <= 1'b0;
				cnt_q[i] <= '0;
			end
			chain_q <= 1'b1;
		end else if (accept) begin
			err_q <= err_d;
			st_q <= st_d;
			tx_q <= tx_d;
			isv_q <= isv_d;
			cnt_q <= cnt_d;
			chain_q <= chain_d;
		end
	end

	// Response valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Response payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.int_line <= chain_d && nxt_scan.hit;
			rsp_q.chain_out <= chain_d && !isv_d[0] && !isv_d[1];
			rsp_q.request_pending <= nxt_scan.any_req;
			rsp_q.vector_out <= nxt_scan.vector;
			rsp_q.ack_data <= ack_d;
		end
	end

endmodule

### rtl/vidc_checker.sv
// ----------------------------------------------------------------------------
// vidc_checker
// Port-level assertions for the vectored interrupt daisy chain.
// ----------------------------------------------------------------------------
`include "vectored_interrupt_daisy_chain_macros.svh"

module vidc_checker
	import vidc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	// A stalled response keeps its payload.
	`VIDC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

	// Every accepted transaction shows a response in the following cycle.
	`VIDC_ASSERT_NEXT(a_rsp_follows, req_valid && !req_stall, rsp_valid)

	// The request side stalls only behind a waiting response.
	`VIDC_ASSERT_NOW(a_stall_cause, req_stall, rsp_valid && rsp_stall)

	// A granted acknowledge puts a channel in service, which blocks the chain.
	`VIDC_ASSERT_NOW(a_ack_blocks_chain, rsp_valid && (rsp.ack_data != ACK_NONE),
		!rsp.chain_out)

	// The interrupt line needs a pending request.
	`VIDC_ASSERT_NOW(a_line_needs_req, rsp_valid && rsp.int_line, rsp.request_pending)

endmodule

bind vectored_interrupt_daisy_chain vidc_checker u_vidc_checker (.*);

### tb/vidc_interrupt_monitor.sv
// ----------------------------------------------------------------------------
// vidc_interrupt_monitor
// Watches the event, response and register channels of the vectored
// interrupt daisy chain. It keeps its own copy of the channel flags,
// receive counts, in-service flags and registers, works out the response
// to each accepted event, and compares every response taken from the
// block with the oldest response still due.
// ----------------------------------------------------------------------------
module vidc_interrupt_monitor
	import vidc_pkg::*;
#(
	parameter int RX_LIMIT = 15
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic       req_stall,
	input  req_t       req,
	input  logic       rsp_valid,
	input  logic       rsp_stall,
	input  rsp_t       rsp,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	output int         fail_count,
	output int         pending_results
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RXW = $clog2(RX_LIMIT + 1);
	localparam int NO_SOURCE = -1;
	localparam int REPORT_LIMIT = 10;

	// Register copies.
	logic [ENABLE_W-1:0] chan_en [2];
	logic [7:0]          base_vec;

	// Channel state.
	logic           err_flag [2];
	logic [RXW-1:0] rx_count [2];
	logic           st_flag [2];
	logic           tx_flag [2];
	logic           in_service_flag [2];
	logic           chain_in_level;

	rsp_t due_responses [$];
	int   errors = 0;

	assign fail_count = errors;

	// Highest enabled request of one channel, or none.
	function automatic int top_source(input int ch);
		if (err_flag[ch])
			return int'(SRC_ERR);
		if (rx_count[ch] != 0 && (chan_en[ch] & RX_MODE_MASK) != 0)
			return int'(SRC_RX);
		if (st_flag[ch] && chan_en[ch][ENB_STATUS])
			return int'(SRC_STATUS);
		if (tx_flag[ch] && chan_en[ch][ENB_TX])
			return int'(SRC_TX);
		return NO_SOURCE;
	endfunction

	// Vector as presented now, with the status-affects-vector rewrite.
	function automatic logic [7:0] vector_now();
		logic [2:0] code;
		int         src;
		code = CODE_NONE;
		if (!chan_en[1][ENB_SAV])
			return base_vec;
		if (!in_service_flag[0]) begin
			src = top_source(0);
			if (src != NO_SOURCE) begin
				code = {1'b1, src[1:0]};
			end else if (!in_service_flag[1]) begin
				src = top_source(1);
				if (src != NO_SOURCE)
					code = {1'b0, src[1:0]};
			end
		end
		return (base_vec & VEC_KEEP_MASK) | {4'b0, code, 1'b0};
	endfunction

	// Applies one event to the state copy and returns the response it gives.
	function automatic rsp_t apply_event(input req_t ev);
		rsp_t       r;
		int         src0;
		int         src1;
		int         grant_ch;
		int         grant_src;
		logic [7:0] ack;
		ack = ACK_NONE;
		grant_ch = NO_SOURCE;
		grant_src = NO_SOURCE;
		case (ev.req_type)
			REQ_RAISE: begin
				case (ev.source)
					SRC_TX: tx_flag[ev.channel] = 1'b1;
					SRC_STATUS: st_flag[ev.channel] = 1'b1;
					SRC_RX: begin
						if (rx_count[ev.channel] < RX_LIMIT)
							rx_count[ev.channel] = rx_count[ev.channel] + 1'b1;
					end
					default: err_flag[ev.channel] = 1'b1;
				endcase
			end
			REQ_CLEAR: begin
				case (ev.source)
					SRC_TX: tx_flag[ev.channel] = 1'b0;
					SRC_STATUS: st_flag[ev.channel] = 1'b0;
					SRC_RX: begin
						if (rx_count[ev.channel] != 0)
							rx_count[ev.channel] = rx_count[ev.channel] - 1'b1;
					end
					default: err_flag[ev.channel] = 1'b0;
				endcase
			end
			REQ_RESET: begin
				err_flag[ev.channel] = 1'b0;
				rx_count[ev.channel] = '0;
				st_flag[ev.channel] = 1'b0;
				tx_flag[ev.channel] = 1'b0;
			end
			REQ_ACK: begin
				// A channel in service blocks everything behind it.
				src0 = top_source(0);
				src1 = top_source(1);
				if (!in_service_flag[0]) begin
					if (src0 != NO_SOURCE) begin
						grant_ch = 0;
						grant_src = src0;
					end else if (!in_service_flag[1] && src1 != NO_SOURCE) begin
						grant_ch = 1;
						grant_src = src1;
					end
				end
				if (grant_ch != NO_SOURCE) begin
					ack = vector_now();
					case (grant_src[1:0])
						SRC_ERR: err_flag[grant_ch] = 1'b0;
						SRC_STATUS: st_flag[grant_ch] = 1'b0;
						SRC_TX: tx_flag[grant_ch] = 1'b0;
						default: ;
					endcase
					in_service_flag[grant_ch] = 1'b1;
				end
			end
			REQ_RETURN: begin
				if (in_service_flag[0])
					in_service_flag[0] = 1'b0;
				else if (in_service_flag[1])
					in_service_flag[1] = 1'b0;
			end
			REQ_CHAIN: chain_in_level = ev.chain_in_value;
			default: ;
		endcase

		// Lines as they stand after the event.
		src0 = top_source(0);
		src1 = top_source(1);
		r.int_line = chain_in_level && !in_service_flag[0] &&
			(src0 != NO_SOURCE || (!in_service_flag[1] && src1 != NO_SOURCE));
		r.chain_out = chain_in_level && !in_service_flag[0] && !in_service_flag[1];
		r.request_pending = (src0 != NO_SOURCE) || (src1 != NO_SOURCE);
		r.vector_out = vector_now();
		r.ack_data = ack;
		return r;
	endfunction

	task automatic compare_field(input string name, input logic [7:0] want_v,
			input logic [7:0] got_v);
		if (got_v !== want_v) begin
			if (errors < REPORT_LIMIT)
				$display("%0t: %s mismatch, expected %02h, got %02h", $realtime, name,
					want_v, got_v);
			errors++;
		end
	endtask

	// Track every transaction at the clock edge where it completes.
	always @(posedge clk or negedge arst_n) begin
		rsp_t got;
		rsp_t want;
		if (!arst_n) begin
			for (int ch = 0; ch < 2; ch++) begin
				chan_en[ch] = '0;
				err_flag[ch] = 1'b0;
				rx_count[ch] = '0;
				st_flag[ch] = 1'b0;
				tx_flag[ch] = 1'b0;
				in_service_flag[ch] = 1'b0;
			end
			base_vec = '0;
			chain_in_level = 1'b1;
			due_responses.delete();
			pending_results <= 0;
		end else begin
			// Register writes; index three has no register behind it.
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_CHAN_A: chan_en[0] = cfg_data[ENABLE_W-1:0];
					CFG_CHAN_B: chan_en[1] = cfg_data[ENABLE_W-1:0];
					CFG_BASE: base_vec = cfg_data;
					default: ;
				endcase
			end

			// A response taken now belongs to an event accepted earlier.
			if (rsp_valid && !rsp_stall) begin
				got = rsp;
				if (due_responses.size() == 0) begin
					if (errors < REPORT_LIMIT)
						$display("%0t: response %h arrived with none due", $realtime, got);
					errors++;
				end else begin
					want = due_responses.pop_front();
					compare_field("int_line", 8'(want.int_line), 8'(got.int_line));
					compare_field("chain_out", 8'(want.chain_out), 8'(got.chain_out));
					compare_field("request_pending", 8'(want.request_pending),
						8'(got.request_pending));
					compare_field("vector_out", want.vector_out, got.vector_out);
					compare_field("ack_data", want.ack_data, got.ack_data);
				end
			end

			if (req_valid && !req_stall)
				due_responses.push_back(apply_event(req));

			pending_results <= due_responses.size();
		end
	end

endmodule

### tb/vectored_interrupt_daisy_chain_test.sv
// ----------------------------------------------------------------------------
// vectored_interrupt_daisy_chain_test
// Drives events and register writes into the interrupt unit and gives the
// verdict. A short directed sequence walks every event type and the corner
// cases of acknowledge and return; phases of random traffic follow, each
// under its own register setting, built mostly from raise, acknowledge and
// return episodes with receive bursts and noise mixed in. Both sides idle
// at random; one phase holds off the receiver for a long stretch, one
// pauses the sender until the block drains, and one runs without gaps.
// ----------------------------------------------------------------------------
module vectored_interrupt_daisy_chain_test;
	import vidc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RX_LIMIT = 15;
	localparam int PHASE_COUNT = 8;
	localparam int PHASE_EVENTS = 180;
	localparam int RSP_HOLD_CYCLES = 150;
	localparam int DRAIN_CYCLES = 3;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic [1:0] CFG_UNUSED = 2'd3;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       req_valid = 1'b0;
	logic       req_stall;
	req_t       req = '0;
	logic       rsp_valid;
	logic       rsp_stall = 1'b0;
	rsp_t       rsp;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;

	int   fail_count;
	int   pending_results;
	int   cycle_count = 0;
	logic no_idle = 1'b0;
	logic hold_go = 1'b0;

	vectored_interrupt_daisy_chain #(
		.RECV_COUNT_MAX(RX_LIMIT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	vidc_interrupt_monitor #(
		.RX_LIMIT(RX_LIMIT)
	) monitor (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.pending_results(pending_results)
	);

	// 100 MHz clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Run limit.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("== FAIL ==");
		$finish;
	end

	// Response side: random stalls, plus one long hold-off on request.
	initial begin
		logic hold_seen;
		hold_seen = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_go != hold_seen) begin
				hold_seen = hold_go;
				rsp_stall <= 1'b1;
				repeat (RSP_HOLD_CYCLES) @(posedge clk);
			end
			rsp_stall <= !no_idle && ($urandom_range(99) < 13);
		end
	end

	function automatic req_t make_event(input logic [2:0] kind, input logic ch,
			input logic [1:0] src, input logic lvl);
		req_t ev;
		ev.req_type = kind;
		ev.channel = ch;
		ev.source = src;
		ev.chain_in_value = lvl;
		return ev;
	endfunction

	// Offers one event and returns at the edge where it is accepted, with
	// valid still high so that a following event can go out back to back.
	task automatic send_event(input req_t ev);
		while (!no_idle && $urandom_range(99) < 13) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= ev;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
	endtask

	// Stops offering and waits until every response due has been taken.
	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	// Writes all registers, and the unused index with junk, while idle.
	task automatic configure(input logic [4:0] a_en, input logic [4:0] b_en,
			input logic [7:0] base);
		write_reg(CFG_UNUSED, 8'($urandom));
		write_reg(CFG_CHAN_A, {3'($urandom), a_en});
		write_reg(CFG_CHAN_B, {3'($urandom), b_en});
		write_reg(CFG_BASE, base);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [2:0] pick_kind();
		int roll;
		roll = $urandom_range(99);
		if (roll < 30)
			return REQ_RAISE;
		if (roll < 50)
			return REQ_CLEAR;
		if (roll < 58)
			return REQ_RESET;
		if (roll < 75)
			return REQ_ACK;
		if (roll < 90)
			return REQ_RETURN;
		return REQ_CHAIN;
	endfunction

	// Random traffic: mostly raise/acknowledge/return episodes. Events of
	// the unused types do not count toward the target.
	task automatic run_random(input int target, input bit pause_midway);
		req_t       batch [$];
		int         sent;
		int         roll;
		int         len;
		bit         paused;
		logic       ch;
		logic [2:0] kind;
		sent = 0;
		paused = 1'b0;
		while (sent < target) begin
			batch.delete();
			roll = $urandom_range(99);
			if (roll < 45) begin
				// Raise a few sources, acknowledge, usually return.
				len = $urandom_range(1, 4);
				repeat (len)
					batch.push_back(make_event(REQ_RAISE, 1'($urandom), 2'($urandom),
						1'($urandom)));
				batch.push_back(make_event(REQ_ACK, 1'($urandom), 2'($urandom),
					1'($urandom)));
				if ($urandom_range(3) != 0)
					batch.push_back(make_event(REQ_RETURN, 1'($urandom), 2'($urandom),
						1'($urandom)));
			end else if (roll < 55) begin
				// Receive burst, long enough at times to saturate the count.
				ch = 1'($urandom);
				len = $urandom_range(1, 20);
				repeat (len)
					batch.push_back(make_event(REQ_RAISE, ch, SRC_RX, 1'($urandom)));
				batch.push_back(make_event(REQ_ACK, 1'($urandom), 2'($urandom),
					1'($urandom)));
			end else if (roll < 90) begin
				kind = pick_kind();
				if (kind == REQ_CHAIN)
					batch.push_back(make_event(kind, 1'($urandom), 2'($urandom),
						$urandom_range(3) != 0));
				else
					batch.push_back(make_event(kind, 1'($urandom), 2'($urandom),
						1'($urandom)));
			end else begin
				// Noise over the whole event encoding, unused types included.
				batch.push_back(req_t'($urandom_range(127)));
			end

			foreach (batch[i]) begin
				send_event(batch[i]);
				if (batch[i].req_type <= REQ_CHAIN)
					sent++;
			end

			if (pause_midway && !paused && sent >= target / 2) begin
				wait_drained();
				paused = 1'b1;
			end
		end
	endtask

	// Main sequence.
	initial begin
		req_t       directed [$];
		logic [4:0] a_en;
		logic [4:0] b_en;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed walk: all sources, priority, acknowledge while in service,
		// receive count at zero, channel reset, chain enable in, unused types.
		configure(5'h1b, 5'h1f, 8'h5a);
		directed.push_back(make_event(REQ_RAISE, 1'b0, SRC_TX, 1'b0));
		directed.push_back(make_event(REQ_RAISE, 1'b0, SRC_STATUS, 1'b0));
		directed.push_back(make_event(REQ_RAISE, 1'b0, SRC_RX, 1'b0));
		directed.push_back(make_event(REQ_RAISE, 1'b0, SRC_ERR, 1'b0));
		directed.push_back(make_event(REQ_RAISE, 1'b1, SRC_ERR, 1'b1));
		directed.push_back(make_event(REQ_ACK, 1'b0, SRC_TX, 1'b0));
		directed.push_back(make_event(REQ_ACK, 1'b1, SRC_ERR, 1'b1));
		directed.push_back(make_event(REQ_RETURN, 1'b0, SRC_TX, 1'b0));
		directed.push_back(make_event(REQ_CLEAR, 1'b0, SRC_RX, 1'b0));
		directed.push_back(make_event(REQ_CLEAR, 1'b0, SRC_RX, 1'b1));
		directed.push_back(make_event(REQ_RAISE, 1'b1, SRC_STATUS, 1'b0));
		directed.push_back(make_event(REQ_RESET, 1'b0, SRC_ERR, 1'b0));
		directed.push_back(make_event(REQ_ACK, 1'b0, SRC_TX, 1'b0));
		directed.push_back(make_event(REQ_CHAIN, 1'b1, SRC_ERR, 1'b0));
		directed.push_back(make_event(REQ_RAISE, 1'b0, SRC_TX, 1'b1));
		directed.push_back(make_event(REQ_RETURN, 1'b1, SRC_RX, 1'b1));
		directed.push_back(make_event(REQ_CHAIN, 1'b0, SRC_TX, 1'b1));
		directed.push_back(make_event(REQ_ACK, 1'b0, SRC_TX, 1'b0));
		directed.push_back(make_event(REQ_RETURN, 1'b0, SRC_TX, 1'b0));
		directed.push_back(make_event(REQ_ACK, 1'b1, SRC_STATUS, 1'b0));
		directed.push_back(make_event(REQ_RETURN, 1'b0, SRC_TX, 1'b0));
		directed.push_back(make_event(REQ_ACK, 1'b0, SRC_TX, 1'b0));
		directed.push_back(make_event(3'd6, 1'b1, SRC_ERR, 1'b1));
		directed.push_back(make_event(3'd7, 1'b0, SRC_RX, 1'b0));
		directed.push_back(make_event(REQ_CLEAR, 1'b1, SRC_TX, 1'b0));
		directed.push_back(make_event(REQ_RETURN, 1'b1, SRC_STATUS, 1'b1));
		foreach (directed[i])
			send_event(directed[i]);
		wait_drained();

		// Random phases, each under its own register setting.
		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			a_en = 5'($urandom);
			b_en = 5'($urandom);
			case (phase)
				0: configure(5'h00, 5'h00, 8'h00);
				1: configure(5'h1f, 5'h1f, 8'hff);
				4: configure(5'h1f, 5'h1b, 8'h00);
				6: configure(5'h18, 5'h1c, 8'($urandom));
				default: begin
					if (phase == 2 || phase == 7)
						b_en[ENB_SAV] = 1'b1;
					configure(a_en, b_en, 8'($urandom));
				end
			endcase

			// Long receiver hold-off while the sender keeps offering.
			if (phase == 1)
				hold_go <= !hold_go;
			// A stretch with no gaps on either side.
			if (phase == 3)
				no_idle <= 1'b1;

			run_random(PHASE_EVENTS, phase == 2);
			wait_drained();

			if (phase == 3)
				no_idle <= 1'b0;
		end

		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
